>>> sv/itrd_pkg.sv
// Shared types, constants and the digit encoder for the radix digit converter.
package itrd_pkg;

  // Width of the value and of the bit counter that walks it.
  localparam int ITRD_VALUE_W = 64;
  localparam int ITRD_BCNT_W  = 6;

  // Default number of digits per request.
  localparam int ITRD_DIGITS = 64;

  // Output field widths.
  localparam int ITRD_POS_W  = 6;
  localparam int ITRD_CHAR_W = 7;
  localparam int ITRD_REM_W  = 6;
  localparam int ITRD_BASE_W = 8;

  // Legal radix range.
  localparam logic [ITRD_BASE_W-1:0] ITRD_BASE_MIN = 8'd2;
  localparam logic [ITRD_BASE_W-1:0] ITRD_BASE_MAX = 8'd36;

  // ASCII anchors for the two digit ranges.
  localparam logic [ITRD_CHAR_W-1:0] ITRD_ASCII_ZERO = 7'd48;
  localparam logic [ITRD_CHAR_W-1:0] ITRD_ASCII_A    = 7'd97;
  localparam logic [ITRD_REM_W-1:0]  ITRD_DEC_LIMIT  = 6'd10;

  // One quotient bit travelling from one divider row to the next.
  typedef struct packed {
    logic                  valid;
    logic                  data;
    logic                  first;
    logic                  lastb;
    logic                  ok;
    logic [ITRD_REM_W-1:0] base;
  } itrd_bit_t;

  // Finished remainder of one divider row.
  typedef struct packed {
    logic                  valid;
    logic                  ok;
    logic [ITRD_REM_W-1:0] rem;
  } itrd_dig_t;

  // Result word merged across all rows.
  typedef struct packed {
    logic                  valid;
    logic                  ok;
    logic                  last;
    logic [ITRD_POS_W-1:0] pos;
    logic [ITRD_REM_W-1:0] rem;
  } itrd_res_t;

  // Map a remainder to its ASCII digit, 0-9 then a-z.
  function automatic logic [ITRD_CHAR_W-1:0] itrd_char(input logic [ITRD_REM_W-1:0] rem);
    logic [ITRD_CHAR_W-1:0] rem_ext;
    rem_ext = {1'b0, rem};
    if (rem < ITRD_DEC_LIMIT) begin
      return ITRD_ASCII_ZERO + rem_ext;
    end else begin
      return ITRD_ASCII_A + rem_ext - {1'b0, ITRD_DEC_LIMIT};
    end
  endfunction

endpackage

>>> sv/itrd_cell.sv
// One divider row: a bit-serial restoring division step per cycle.
module itrd_cell
  import itrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  itrd_bit_t bit_i,
  output itrd_bit_t bit_o,
  output itrd_dig_t dig_o
);

  logic [ITRD_REM_W-1:0] rem_q, rem_d;
  logic [ITRD_REM_W-1:0] rem_in;
  logic [ITRD_REM_W:0]   trial;
  logic [ITRD_REM_W:0]   base_ext;
  logic                  ge;
  logic                  valid_q;
  itrd_bit_t             bit_q, bit_d;
  itrd_dig_t             dig_q, dig_d;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    rem_in   = bit_i.first ? '0 : rem_q;
    trial    = {rem_in, bit_i.data};
    base_ext = {1'b0, bit_i.base};
    ge       = (trial >= base_ext);
    rem_d    = ge ? ITRD_REM_W'(trial - base_ext) : ITRD_REM_W'(trial);
  end

  // The quotient bit is registered and feeds the next row in the following cycle.
  always_comb begin
    bit_d       = bit_i;
    bit_d.data  = ge;
    dig_d       = '0;
    if (bit_i.valid && bit_i.lastb) begin
      dig_d.valid = 1'b1;
      dig_d.ok    = bit_i.ok;
      dig_d.rem   = rem_d;
    end
  end

  // Control and the digit word are reset; the remainder is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dig_q   <= '0;
    end else begin
      valid_q <= bit_d.valid;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    if (bit_i.valid) begin
      rem_q <= rem_d;
    end
  end

  // The outgoing bit takes its valid flag from the reset register.
  always_comb begin
    bit_o       = bit_q;
    bit_o.valid = valid_q;
  end

  assign dig_o = dig_q;

endmodule

>>> sv/itrd_collect.sv
// Registered two-level OR tree that merges the one-hot row results.
module itrd_collect
  import itrd_pkg::*;
#(
  parameter int DIGIT_COUNT = ITRD_DIGITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  itrd_res_t res_i [DIGIT_COUNT],
  output itrd_res_t res_o
);

  localparam int GroupSize = 8;
  localparam int Groups    = (DIGIT_COUNT + GroupSize - 1) / GroupSize;

  itrd_res_t grp_q [Groups];
  itrd_res_t grp_d [Groups];
  itrd_res_t top_q, top_d;

  // First level: OR each group of eight rows.
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if (g * GroupSize + j < DIGIT_COUNT) begin
          grp_d[g] = grp_d[g] | res_i[g * GroupSize + j];
        end
      end
    end
  end

  // Second level: OR the group results.
  always_comb begin
    top_d = '0;
    for (int g = 0; g < Groups; g++) begin
      top_d = top_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < Groups; g++) begin
        grp_q[g] <= '0;
      end
      top_q <= '0;
    end else begin
      for (int g = 0; g < Groups; g++) begin
        grp_q[g] <= grp_d[g];
      end
      top_q <= top_d;
    end
  end

  assign res_o = top_q;

endmodule

>>> sv/integer_to_radix_digits.sv
// Top level of the radix digit converter: bit feeder, divider rows and output stage.
//
//   channel  | signals                                  | flow
//   ---------+------------------------------------------+---------------------------
//   request  | start_i, busy_o, value_i, base_i         | taken when start_i && !busy_o
//   result   | strobe_o, position_o, digit_char_o,      | one cycle per result,
//            | last_o                                   | no backpressure
//
// The bit feeder walks a request one value bit per cycle and takes no new request
// before its last bit; the next request may start in the cycle after the last
// bit of the previous one.
// Each divider row after the first divides the quotient stream of the row before
// it, so digit k passes from row k through the two OR tree registers and the output
// registers to the result ports; the results of a request leave on consecutive cycles.
// Reset clears all valid bits; no clearing pass is needed.
// The receiver cannot stall, so no result is ever held back.
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int DIGIT_COUNT = ITRD_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [ITRD_VALUE_W-1:0] value_i,
  input  logic [ITRD_BASE_W-1:0]  base_i,
  output logic                   strobe_o,
  output logic [ITRD_POS_W-1:0]  position_o,
  output logic [ITRD_CHAR_W-1:0] digit_char_o,
  output logic                   last_o
);

  localparam logic [ITRD_BCNT_W-1:0] BcntLast = ITRD_BCNT_W'(ITRD_VALUE_W - 1);

  logic [ITRD_VALUE_W-1:0] shreg_q, shreg_d;
  logic [ITRD_BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic                    active_q, active_d;
  logic [ITRD_REM_W-1:0]   base_q, base_d;
  logic                    ok_q, ok_d;
  logic                    accept;

  itrd_bit_t             feed;
  itrd_bit_t             chain [DIGIT_COUNT];
  itrd_dig_t             dig   [DIGIT_COUNT];
  itrd_res_t             res   [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] row_done;
  itrd_res_t             merged;

  logic                   strobe_q;
  logic [ITRD_POS_W-1:0]  position_q;
  logic [ITRD_CHAR_W-1:0] char_q, char_d;
  logic                   last_q;

  // Bit feeder: a new request may load in the cycle its predecessor sends its last bit.
  assign busy_o = active_q && (bcnt_q != BcntLast);
  assign accept = start_i && !busy_o;

  always_comb begin
    shreg_d  = shreg_q;
    bcnt_d   = bcnt_q;
    active_d = active_q;
    base_d   = base_q;
    ok_d     = ok_q;
    if (accept) begin
      shreg_d  = value_i;
      bcnt_d   = '0;
      active_d = 1'b1;
      ok_d     = (base_i >= ITRD_BASE_MIN) && (base_i <= ITRD_BASE_MAX);
      base_d   = base_i[ITRD_REM_W-1:0];
    end else if (active_q) begin
      shreg_d  = {shreg_q[ITRD_VALUE_W-2:0], 1'b0};
      bcnt_d   = bcnt_q + 1'b1;
      active_d = (bcnt_q != BcntLast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      bcnt_q   <= '0;
    end else begin
      active_q <= active_d;
      bcnt_q   <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    base_q  <= base_d;
    ok_q    <= ok_d;
  end

  // The first row sees the value MSB first.
  always_comb begin
    feed.valid = active_q;
    feed.data  = shreg_q[ITRD_VALUE_W-1];
    feed.first = (bcnt_q == '0);
    feed.lastb = (bcnt_q == BcntLast);
    feed.ok    = ok_q;
    feed.base  = base_q;
  end

  assign chain[0] = feed;

  // Divider rows; row k yields the remainder of the k-th division.
  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_row
    if (k < DIGIT_COUNT - 1) begin : g_mid
      itrd_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .bit_i  (chain[k]),
        .bit_o  (chain[k+1]),
        .dig_o  (dig[k])
      );
    end else begin : g_end
      itrd_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .bit_i  (chain[k]),
        .bit_o  (),
        .dig_o  (dig[k])
      );
    end

    // Tag each row result with its buffer position; zero when idle so it can be ORed.
    always_comb begin
      res[k].valid = dig[k].valid;
      res[k].ok    = dig[k].ok;
      res[k].rem   = dig[k].rem;
      res[k].pos   = dig[k].valid ? ITRD_POS_W'(DIGIT_COUNT - 1 - k) : '0;
      res[k].last  = dig[k].valid && (k == DIGIT_COUNT - 1);
    end
    assign row_done[k] = dig[k].valid;
  end

  itrd_collect #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .res_o  (merged)
  );

  // Output stage: encode the digit, NUL for an illegal base.
  assign char_d = merged.ok ? itrd_char(merged.rem) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= merged.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    position_q <= merged.pos;
    char_q     <= char_d;
    last_q     <= merged.last;
  end

  assign strobe_o     = strobe_q;
  assign position_o   = position_q;
  assign digit_char_o = char_q;
  assign last_o       = strobe_q && last_q;

  // Only one row may finish in any cycle, or the OR tree would mix results.
  a_row_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(row_done))
    else $error("two divider rows finished in the same cycle");

  // The final result of a request sits at position zero.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> position_o == '0)
    else $error("last result not at position zero");

  // Results of one request leave on consecutive cycles with falling positions.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && (position_o == $past(position_o) - 1'b1))
    else $error("result sequence broken");

  // A taken request keeps the feeder busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("feeder not busy after taking a request");

endmodule

>>> bench/integer_to_radix_digits_tb.sv
// Self-checking testbench for the radix digit converter, with a built-in digit predictor.
`timescale 1ns / 1ps

module integer_to_radix_digits_tb
  import itrd_pkg::*;
;

  // One expected character as it should leave the block.
  typedef struct packed {
    logic [ITRD_POS_W-1:0]  pos;
    logic [ITRD_CHAR_W-1:0] ch;
    logic                   last;
  } digit_res_t;

  localparam string DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [ITRD_VALUE_W-1:0] value_i;
  logic [ITRD_BASE_W-1:0]  base_i;
  logic                    strobe_o;
  logic [ITRD_POS_W-1:0]   position_o;
  logic [ITRD_CHAR_W-1:0]  digit_char_o;
  logic                    last_o;

  digit_res_t expected_digits[$];
  int         mismatch_count;
  int         idle_pct;
  int         quiet_cycles;

  integer_to_radix_digits i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_i     (value_i),
    .base_i      (base_i),
    .strobe_o    (strobe_o),
    .position_o  (position_o),
    .digit_char_o(digit_char_o),
    .last_o      (last_o)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Work out the full digit string of one request, least significant first.
  function automatic void predict_digits(input logic [ITRD_VALUE_W-1:0] value,
                                         input logic [ITRD_BASE_W-1:0] base);
    logic [ITRD_VALUE_W-1:0] quotient;
    logic [ITRD_VALUE_W-1:0] radix;
    logic                    base_ok;
    digit_res_t              res;
    quotient = value;
    radix    = ITRD_VALUE_W'(base);
    base_ok  = (base >= ITRD_BASE_MIN) && (base <= ITRD_BASE_MAX);
    for (int k = 0; k < ITRD_DIGITS; k++) begin
      res.pos  = ITRD_POS_W'(ITRD_DIGITS - 1 - k);
      res.ch   = '0;
      res.last = (k == ITRD_DIGITS - 1);
      if (base_ok) begin
        res.ch   = ITRD_CHAR_W'(DIGIT_SET[int'(quotient % radix)]);
        quotient = quotient / radix;
      end
      expected_digits.push_back(res);
    end
  endfunction

  // Compare every character strobe against the oldest expectation.
  always @(posedge clk_i) begin
    digit_res_t exp_res;
    if (rst_ni && strobe_o) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected character: position %0d, digit_char %0d, last %0d",
               position_o, digit_char_o, last_o);
        mismatch_count++;
      end else begin
        exp_res = expected_digits.pop_front();
        if (position_o !== exp_res.pos) begin
          $error("position mismatch: expected %0d, got %0d", exp_res.pos, position_o);
          mismatch_count++;
        end
        if (digit_char_o !== exp_res.ch) begin
          $error("digit_char mismatch: expected %0d, got %0d", exp_res.ch, digit_char_o);
          mismatch_count++;
        end
        if (last_o !== exp_res.last) begin
          $error("last mismatch: expected %0d, got %0d", exp_res.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither a request nor a character moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || strobe_o || (start_i && !busy_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("integer_to_radix_digits verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until the block is ready, idle for random cycles, then offer one request.
  task automatic send_request(input logic [ITRD_VALUE_W-1:0] value,
                              input logic [ITRD_BASE_W-1:0] base);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= value;
    base_i  <= base;
    @(posedge clk_i);
    predict_digits(value, base);
  endtask

  // Random value whose magnitude spans from one bit to the full width.
  function automatic logic [ITRD_VALUE_W-1:0] random_value();
    logic [ITRD_VALUE_W-1:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(9) == 0) begin
      return raw;
    end
    return raw >> $urandom_range(0, ITRD_VALUE_W - 1);
  endfunction

  // Mostly legal radixes, the rest spread over the illegal ones.
  function automatic logic [ITRD_BASE_W-1:0] random_base();
    case ($urandom_range(19))
      0: return 8'd0;
      1: return 8'd1;
      2, 3: return ITRD_BASE_W'($urandom_range(37, 255));
      default: return ITRD_BASE_W'($urandom_range(2, 36));
    endcase
  endfunction

  // Extremes of value and radix, and every illegal radix class.
  task automatic test_directed();
    send_request('0, 8'd10);
    send_request('1, 8'd2);
    send_request({ITRD_VALUE_W{1'b1}}, 8'd2);
    send_request({ITRD_VALUE_W{1'b1}}, 8'd36);
    send_request({ITRD_VALUE_W{1'b1}}, 8'd10);
    send_request({ITRD_VALUE_W{1'b1}}, 8'd16);
    send_request(64'h8000_0000_0000_0000, 8'd2);
    send_request(64'h0123_4567_89ab_cdef, 8'd16);
    send_request(64'd35, 8'd36);
    send_request(64'd36, 8'd36);
    send_request(64'd1295, 8'd36);
    send_request(64'd511, 8'd8);
    send_request(64'd12345678901234567890, 8'd10);
    send_request(64'haaaa_aaaa_aaaa_aaaa, 8'd3);
    send_request(64'h5555_5555_5555_5555, 8'd7);
    send_request({ITRD_VALUE_W{1'b1}}, 8'd35);
    // Illegal radixes still give a full string of NUL characters.
    send_request({ITRD_VALUE_W{1'b1}}, 8'd0);
    send_request(64'd12345, 8'd1);
    send_request(64'd12345, 8'd37);
    send_request({ITRD_VALUE_W{1'b1}}, 8'd255);
    send_request(64'd99, 8'd128);
  endtask

  // Random requests with random gaps between them.
  task automatic test_random(input int count);
    idle_pct = 17;
    repeat (count) send_request(random_value(), random_base());
  endtask

  // Back-to-back requests with no gaps at all.
  task automatic test_back_to_back(input int count);
    idle_pct = 0;
    repeat (count) send_request(random_value(), random_base());
    idle_pct = 17;
  endtask

  // Stop offering requests and let every expected character come out.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (expected_digits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    idle_pct       = 17;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    value_i        = '0;
    base_i         = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(110);
    test_back_to_back(40);
    test_random(110);
    drain_results();

    if (mismatch_count == 0) begin
      $display("integer_to_radix_digits verification clean");
    end else begin
      $display("integer_to_radix_digits verification failed");
    end
    $finish;
  end

endmodule
